### rtl/ubf_pkg.sv
// ----------------------------------------------------------------------------
// ubf_pkg
// Shared types and constants of the buffered UART receive/transmit queues.
// ----------------------------------------------------------------------------
package ubf_pkg;

  localparam int DEF_RX_DEPTH = 64;
  localparam int DEF_TX_DEPTH = 64;

  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int FLAG_W  = 2;
  localparam int OP_W    = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register select bit of paddr and register indexes
  localparam int       REG_SEL_BIT = 2;
  localparam logic     REG_RX_CAP  = 1'b0;
  localparam logic     REG_TX_CAP  = 1'b1;

  localparam logic [OP_W-1:0] OP_RX_EVENT   = 3'd0;
  localparam logic [OP_W-1:0] OP_TX_READY   = 3'd1;
  localparam logic [OP_W-1:0] OP_HOST_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_HOST_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_FLAGS = 3'd4;

  localparam int FLAG_HW = 0;
  localparam int FLAG_SW = 1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx_data;
    logic              rx_not_empty;
    logic              rx_overrun;
    logic [BYTE_W-1:0] write_byte;
    logic [LEN_W-1:0]  burst_length;
    logic              tx_reg_empty;
    logic [FLAG_W-1:0] clear_mask;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              last;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_irq_enable;
    logic [FLAG_W-1:0] flags;
    logic [LEN_W-1:0]  rx_level;
    logic [LEN_W-1:0]  tx_level;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic tx_rd;
    logic rx_rd;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop;
    logic burst;
    logic more;
    logic out_free;
  } status_t;

endpackage

### rtl/ubf_ram.sv
// ----------------------------------------------------------------------------
// ubf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ubf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ubf_ctrl.sv
// ----------------------------------------------------------------------------
// ubf_ctrl
// Sequencer: request intake, execute, queue read and result hand-off.
// ----------------------------------------------------------------------------
module ubf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ubf_pkg::status_t st,
  output ubf_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TXRD,
    S_RXRD,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.pop) begin
          state_nxt = S_TXRD;
        end else if (st.burst) begin
          state_nxt = S_RXRD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_TXRD: begin
        cmd.tx_rd = 1'b1;
        state_nxt = S_EMIT;
      end
      S_RXRD: begin
        cmd.rx_rd = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.more ? S_RXRD : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

### rtl/ubf_dp.sv
// ----------------------------------------------------------------------------
// ubf_dp
// Queue state, sticky flags, burst tracking, configuration and result register.
// ----------------------------------------------------------------------------
module ubf_dp #(
  parameter int RX_DEPTH = ubf_pkg::DEF_RX_DEPTH,
  parameter int TX_DEPTH = ubf_pkg::DEF_TX_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ubf_pkg::in_item_t              in_data,
  input  ubf_pkg::cmd_t                  cmd,
  output ubf_pkg::status_t               st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ubf_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ubf_pkg::PADDR_W-1:0]    paddr,
  input  logic [ubf_pkg::PDATA_W-1:0]    pwdata,
  output logic [ubf_pkg::PDATA_W-1:0]    prdata
);

  localparam int RIW = $clog2(RX_DEPTH);
  localparam int RLW = $clog2(RX_DEPTH + 1);
  localparam int TIW = $clog2(TX_DEPTH);
  localparam int TLW = $clog2(TX_DEPTH + 1);
  localparam int LW  = ubf_pkg::LEN_W;

  ubf_pkg::in_item_t  item_r;
  ubf_pkg::out_item_t out_r;
  ubf_pkg::out_item_t out_nxt;

  logic [RIW-1:0] rx_wi_r, rx_ri_r;
  logic [RLW-1:0] rx_cnt_r, rx_cap_r, rx_left_r;
  logic [TIW-1:0] tx_wi_r, tx_ri_r;
  logic [TLW-1:0] tx_cnt_r, tx_cap_r;
  logic [ubf_pkg::FLAG_W-1:0] sticky_r;
  logic           irq_r;
  logic [LW-1:0]  bleft_r;
  logic           bacc_r;
  logic           ok_r;
  logic           pop_r;
  logic           rxb_r;
  logic           out_valid_r;

  logic [RLW-1:0] rx_wi_inc, rx_ri_inc;
  logic [RIW-1:0] rx_wi_adv, rx_ri_adv;
  logic [TLW-1:0] tx_wi_inc, tx_ri_inc, tx_free;
  logic [TIW-1:0] tx_wi_adv, tx_ri_adv;
  logic [LW-1:0]  blen, bleft0;
  logic           bstart, bacc, bfinish, tx_wr, kick, rx_wr, rd_ok;
  logic           cfg_wr;
  logic [RLW-1:0] rx_cap_new;
  logic [TLW-1:0] tx_cap_new;
  logic [ubf_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;

  // ring index advance, wrapping at capacity
  assign rx_wi_inc = RLW'(rx_wi_r) + RLW'(1);
  assign rx_ri_inc = RLW'(rx_ri_r) + RLW'(1);
  assign tx_wi_inc = TLW'(tx_wi_r) + TLW'(1);
  assign tx_ri_inc = TLW'(tx_ri_r) + TLW'(1);
  assign rx_wi_adv = (rx_wi_inc >= rx_cap_r) ? '0 : rx_wi_inc[RIW-1:0];
  assign rx_ri_adv = (rx_ri_inc >= rx_cap_r) ? '0 : rx_ri_inc[RIW-1:0];
  assign tx_wi_adv = (tx_wi_inc >= tx_cap_r) ? '0 : tx_wi_inc[TIW-1:0];
  assign tx_ri_adv = (tx_ri_inc >= tx_cap_r) ? '0 : tx_ri_inc[TIW-1:0];

  // write burst bookkeeping
  assign tx_free = (tx_cnt_r >= tx_cap_r) ? '0 : tx_cap_r - tx_cnt_r;
  assign blen    = item_r.burst_length;
  assign bstart  = (bleft_r == '0);
  assign bacc    = bstart ? (LW'(tx_free) >= blen) : bacc_r;
  assign bleft0  = bstart ? blen : bleft_r;
  assign tx_wr   = (bleft0 != '0) && bacc && (tx_cnt_r < tx_cap_r);
  assign bfinish = (bstart && (blen == '0)) || (bleft0 == LW'(1));
  assign kick    = bfinish && bacc && item_r.tx_reg_empty && ((tx_cnt_r != '0) || tx_wr);

  assign rx_wr   = item_r.rx_not_empty && (rx_cnt_r < rx_cap_r);
  assign rd_ok   = (LW'(rx_cnt_r) >= blen);

  assign st.pop      = ((item_r.op == ubf_pkg::OP_TX_READY) && (tx_cnt_r != '0)) ||
                       ((item_r.op == ubf_pkg::OP_HOST_WRITE) && kick);
  assign st.burst    = (item_r.op == ubf_pkg::OP_HOST_READ) && rd_ok && (blen != '0);
  assign st.more     = rxb_r && (rx_left_r != '0);
  assign st.out_free = !out_valid_r || out_ready;

  // configuration
  assign cfg_wr     = psel && penable && pwrite;
  assign rx_cap_new = (pwdata == '0) ? RLW'(1) :
                      (pwdata > ubf_pkg::PDATA_W'(RX_DEPTH)) ? RLW'(RX_DEPTH) :
                      pwdata[RLW-1:0];
  assign tx_cap_new = (pwdata == '0) ? TLW'(1) :
                      (pwdata > ubf_pkg::PDATA_W'(TX_DEPTH)) ? TLW'(TX_DEPTH) :
                      pwdata[TLW-1:0];
  assign prdata     = (paddr[ubf_pkg::REG_SEL_BIT] == ubf_pkg::REG_TX_CAP) ?
                      ubf_pkg::PDATA_W'(tx_cap_r) : ubf_pkg::PDATA_W'(rx_cap_r);

  ubf_ram #(.WIDTH(ubf_pkg::BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (cmd.exec && (item_r.op == ubf_pkg::OP_RX_EVENT) && rx_wr),
    .waddr (rx_wi_r),
    .wdata (item_r.rx_data),
    .re    (cmd.rx_rd),
    .raddr (rx_ri_r),
    .rdata (rx_rdata)
  );

  ubf_ram #(.WIDTH(ubf_pkg::BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (cmd.exec && (item_r.op == ubf_pkg::OP_HOST_WRITE) && tx_wr),
    .waddr (tx_wi_r),
    .wdata (item_r.write_byte),
    .re    (cmd.tx_rd),
    .raddr (tx_ri_r),
    .rdata (tx_rdata)
  );

  always_comb begin
    out_nxt               = '0;
    out_nxt.ok            = ok_r;
    out_nxt.read_valid    = rxb_r;
    out_nxt.read_byte     = rxb_r ? rx_rdata : '0;
    out_nxt.last          = rxb_r ? (rx_left_r == '0) : 1'b1;
    out_nxt.tx_valid      = pop_r;
    out_nxt.tx_byte       = pop_r ? tx_rdata : '0;
    out_nxt.tx_irq_enable = irq_r;
    out_nxt.flags         = sticky_r;
    out_nxt.rx_level      = LW'(rx_cnt_r);
    out_nxt.tx_level      = LW'(tx_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wi_r     <= '0;
      rx_ri_r     <= '0;
      rx_cnt_r    <= '0;
      rx_cap_r    <= RLW'(RX_DEPTH);
      rx_left_r   <= '0;
      tx_wi_r     <= '0;
      tx_ri_r     <= '0;
      tx_cnt_r    <= '0;
      tx_cap_r    <= TLW'(TX_DEPTH);
      sticky_r    <= '0;
      irq_r       <= 1'b0;
      bleft_r     <= '0;
      bacc_r      <= 1'b0;
      ok_r        <= 1'b1;
      pop_r       <= 1'b0;
      rxb_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pop_r <= 1'b0;
        rxb_r <= 1'b0;
        ok_r  <= 1'b1;
        unique case (item_r.op)
          ubf_pkg::OP_RX_EVENT: begin
            if (item_r.rx_overrun) begin
              sticky_r[ubf_pkg::FLAG_HW] <= 1'b1;
            end
            if (item_r.rx_not_empty) begin
              if (rx_wr) begin
                rx_wi_r  <= rx_wi_adv;
                rx_cnt_r <= rx_cnt_r + RLW'(1);
              end else begin
                sticky_r[ubf_pkg::FLAG_SW] <= 1'b1;
              end
            end
          end
          ubf_pkg::OP_TX_READY: begin
            if (tx_cnt_r != '0) begin
              pop_r <= 1'b1;
            end else begin
              irq_r <= 1'b0;
            end
          end
          ubf_pkg::OP_HOST_WRITE: begin
            bacc_r  <= bacc;
            ok_r    <= bacc;
            bleft_r <= (bleft0 != '0) ? bleft0 - LW'(1) : '0;
            if (tx_wr) begin
              tx_wi_r  <= tx_wi_adv;
              tx_cnt_r <= tx_cnt_r + TLW'(1);
            end
            if (bfinish && bacc) begin
              irq_r <= 1'b1;
            end
            pop_r <= kick;
          end
          ubf_pkg::OP_HOST_READ: begin
            ok_r <= rd_ok;
            if (st.burst) begin
              rx_cnt_r  <= rx_cnt_r - RLW'(blen);
              rx_left_r <= RLW'(blen);
              rxb_r     <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.tx_rd) begin
        tx_ri_r  <= tx_ri_adv;
        tx_cnt_r <= tx_cnt_r - TLW'(1);
        if ((item_r.op == ubf_pkg::OP_TX_READY) && (tx_cnt_r == TLW'(1))) begin
          irq_r <= 1'b0;
        end
      end
      if (cmd.rx_rd) begin
        rx_ri_r   <= rx_ri_adv;
        rx_left_r <= rx_left_r - RLW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (item_r.op == ubf_pkg::OP_READ_FLAGS) begin
          sticky_r <= sticky_r & ~item_r.clear_mask;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[ubf_pkg::REG_SEL_BIT] == ubf_pkg::REG_RX_CAP) begin
          rx_cap_r <= rx_cap_new;
          rx_wi_r  <= '0;
          rx_ri_r  <= '0;
          rx_cnt_r <= '0;
        end else begin
          tx_cap_r <= tx_cap_new;
          tx_wi_r  <= '0;
          tx_ri_r  <= '0;
          tx_cnt_r <= '0;
          bleft_r  <= '0;
          bacc_r   <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_rx_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= rx_cap_r) else $error("rx fill exceeds capacity");
  a_tx_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r <= tx_cap_r) else $error("tx fill exceeds capacity");
  a_idx_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (RLW'(rx_ri_r) < rx_cap_r) && (TLW'(tx_ri_r) < tx_cap_r))
    else $error("read index beyond capacity");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r) else $error("result lost after emit");

endmodule

### rtl/uart_buffered_rx_tx_fifo_core.sv
// ----------------------------------------------------------------------------
// uart_buffered_rx_tx_fifo_core
// Receive and transmit byte queues between a UART and a host.
//
// Requests enter on in_valid/in_ready as in_data; results leave on
// out_valid/out_ready as out_data. A request yields one result, except a
// host read burst, which yields one result per byte with the last mark set
// on the final one. Capacities are written over the APB port (word 0 rx,
// word 1 tx); a write empties that queue.
// Each request runs through the execute and emit states, with a queue read
// state between them when a transmit byte is popped or a read burst starts; a
// read burst reads and emits its bytes in turn. The next request is taken once
// the last result of the previous one is in the output register, so requests
// do not overlap; the pace is set by the sequencer and the registered RAM read.
// Reset empties both queues, clears flags, interrupt enable and any open
// burst, and sets both capacities to the full depth. When the receiver
// stalls, the output register holds its result and the block waits.
// ----------------------------------------------------------------------------
module uart_buffered_rx_tx_fifo_core #(
  parameter int RX_DEPTH = ubf_pkg::DEF_RX_DEPTH,
  parameter int TX_DEPTH = ubf_pkg::DEF_TX_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ubf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ubf_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ubf_pkg::PADDR_W-1:0]    paddr,
  input  logic [ubf_pkg::PDATA_W-1:0]    pwdata,
  output logic [ubf_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  ubf_pkg::cmd_t    cmd;
  ubf_pkg::status_t st;

  ubf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ubf_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

  assign pready = 1'b1;

endmodule

### tb/tb_uart_buffered_rx_tx_fifo_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_buffered_rx_tx_fifo_core
// Self-checking bench for the buffered UART receive/transmit queues. Results
// are predicted by an in-bench model of both queues, the sticky flags and the
// host write burst state. Every result is checked field by field in order.
// Directed corners come first, then capacity extremes, then a long output
// hold-off, then random bursts under four handshake pacing modes.
// ----------------------------------------------------------------------------
module tb_uart_buffered_rx_tx_fifo_core;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 10;
  localparam int MAX_SHOWN   = 10;
  localparam int IN_W        = $bits(ubf_pkg::in_item_t);

  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  ubf_pkg::in_item_t           in_data  = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  ubf_pkg::out_item_t          out_data;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [ubf_pkg::PADDR_W-1:0] paddr    = '0;
  logic [ubf_pkg::PDATA_W-1:0] pwdata   = '0;
  logic [ubf_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  uart_buffered_rx_tx_fifo_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // queue model state
  logic [ubf_pkg::BYTE_W-1:0] rx_fifo[$];
  logic [ubf_pkg::BYTE_W-1:0] tx_fifo[$];
  int                         rx_cap    = ubf_pkg::DEF_RX_DEPTH;
  int                         tx_cap    = ubf_pkg::DEF_TX_DEPTH;
  logic [ubf_pkg::FLAG_W-1:0] sticky    = '0;
  logic                       irq_on    = 1'b0;
  int                         burst_rem = 0;
  logic                       burst_ok  = 1'b0;

  ubf_pkg::out_item_t pending_results[$];

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;
  int errors        = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int cycles        = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results pending", cycles,
                 pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a counted hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic ubf_pkg::out_item_t make_result(
    logic ok, logic rv, logic [ubf_pkg::BYTE_W-1:0] rb, logic lst, logic tv,
    logic [ubf_pkg::BYTE_W-1:0] tb, logic [ubf_pkg::FLAG_W-1:0] fl);
    ubf_pkg::out_item_t r;
    r.ok            = ok;
    r.read_valid    = rv;
    r.read_byte     = rb;
    r.last          = lst;
    r.tx_valid      = tv;
    r.tx_byte       = tb;
    r.tx_irq_enable = irq_on;
    r.flags         = fl;
    r.rx_level      = ubf_pkg::LEN_W'(rx_fifo.size());
    r.tx_level      = ubf_pkg::LEN_W'(tx_fifo.size());
    return r;
  endfunction

  function automatic void predict_results(ubf_pkg::in_item_t req);
    logic [ubf_pkg::BYTE_W-1:0] txb;
    logic [ubf_pkg::BYTE_W-1:0] taken[$];
    logic                       tv;
    logic                       finish;
    logic [ubf_pkg::FLAG_W-1:0] prior;
    int                         n;
    txb    = '0;
    tv     = 1'b0;
    finish = 1'b0;
    case (req.op)
      ubf_pkg::OP_RX_EVENT: begin
        if (req.rx_overrun) sticky[ubf_pkg::FLAG_HW] = 1'b1;
        if (req.rx_not_empty) begin
          if (rx_fifo.size() < rx_cap) rx_fifo.push_back(req.rx_data);
          else sticky[ubf_pkg::FLAG_SW] = 1'b1;
        end
        pending_results.push_back(make_result(1'b1, 1'b0, '0, 1'b1, 1'b0, '0, sticky));
      end
      ubf_pkg::OP_TX_READY: begin
        if (tx_fifo.size() > 0) begin
          txb = tx_fifo.pop_front();
          tv  = 1'b1;
        end
        if (tx_fifo.size() == 0) irq_on = 1'b0;
        pending_results.push_back(make_result(1'b1, 1'b0, '0, 1'b1, tv, txb, sticky));
      end
      ubf_pkg::OP_HOST_WRITE: begin
        if (burst_rem == 0) begin
          burst_ok  = ((tx_cap - tx_fifo.size()) >= int'(req.burst_length));
          burst_rem = req.burst_length;
          if (burst_rem == 0) finish = 1'b1;
        end
        if (burst_rem > 0) begin
          if (burst_ok && tx_fifo.size() < tx_cap) tx_fifo.push_back(req.write_byte);
          burst_rem--;
          if (burst_rem == 0) finish = 1'b1;
        end
        if (finish && burst_ok) begin
          if (req.tx_reg_empty && tx_fifo.size() > 0) begin
            txb = tx_fifo.pop_front();
            tv  = 1'b1;
          end
          irq_on = 1'b1;
        end
        pending_results.push_back(make_result(burst_ok, 1'b0, '0, 1'b1, tv, txb, sticky));
      end
      ubf_pkg::OP_HOST_READ: begin
        n = req.burst_length;
        if (n > rx_fifo.size()) begin
          pending_results.push_back(make_result(1'b0, 1'b0, '0, 1'b1, 1'b0, '0, sticky));
        end else if (n == 0) begin
          pending_results.push_back(make_result(1'b1, 1'b0, '0, 1'b1, 1'b0, '0, sticky));
        end else begin
          repeat (n) taken.push_back(rx_fifo.pop_front());
          foreach (taken[i])
            pending_results.push_back(make_result(1'b1, 1'b1, taken[i], (i == n - 1),
                                                  1'b0, '0, sticky));
        end
      end
      ubf_pkg::OP_READ_FLAGS: begin
        prior  = sticky;
        sticky = sticky & ~req.clear_mask;
        pending_results.push_back(make_result(1'b1, 1'b0, '0, 1'b1, 1'b0, '0, prior));
      end
      default: begin
        pending_results.push_back(make_result(1'b1, 1'b0, '0, 1'b1, 1'b0, '0, sticky));
      end
    endcase
  endfunction

  function automatic string diff_fields(ubf_pkg::out_item_t got, ubf_pkg::out_item_t want);
    string s;
    s = "";
    if (got.ok !== want.ok)                       s = {s, " ok"};
    if (got.read_valid !== want.read_valid)       s = {s, " read_valid"};
    if (got.read_byte !== want.read_byte)         s = {s, " read_byte"};
    if (got.last !== want.last)                   s = {s, " last"};
    if (got.tx_valid !== want.tx_valid)           s = {s, " tx_valid"};
    if (got.tx_byte !== want.tx_byte)             s = {s, " tx_byte"};
    if (got.tx_irq_enable !== want.tx_irq_enable) s = {s, " tx_irq_enable"};
    if (got.flags !== want.flags)                 s = {s, " flags"};
    if (got.rx_level !== want.rx_level)           s = {s, " rx_level"};
    if (got.tx_level !== want.tx_level)           s = {s, " tx_level"};
    return s;
  endfunction

  always @(posedge clk) begin : result_check
    ubf_pkg::out_item_t want;
    string              bad;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (errors < MAX_SHOWN)
          $display("[%0t] unexpected result %h with nothing pending", $realtime, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        bad = diff_fields(out_data, want);
        if (bad != "") begin
          if (errors < MAX_SHOWN)
            $display("[%0t] result %0d differs in%s: expected %h actual %h", $realtime,
                     results_seen, bad, want, out_data);
          errors++;
        end
      end
    end
  end

  task automatic send_request(ubf_pkg::in_item_t req);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_results(req);
    requests_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only while idle; a write empties the queue it sizes
  task automatic write_capacity(logic reg_sel, int value);
    int cap;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ubf_pkg::PADDR_W'(reg_sel) << ubf_pkg::REG_SEL_BIT;
    pwdata  <= ubf_pkg::PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cap = (value < 1) ? 1 : value;
    if (reg_sel == ubf_pkg::REG_RX_CAP) begin
      rx_cap = (cap > ubf_pkg::DEF_RX_DEPTH) ? ubf_pkg::DEF_RX_DEPTH : cap;
      rx_fifo.delete();
    end else begin
      tx_cap = (cap > ubf_pkg::DEF_TX_DEPTH) ? ubf_pkg::DEF_TX_DEPTH : cap;
      tx_fifo.delete();
      burst_rem = 0;
      burst_ok  = 1'b0;
    end
  endtask

  task automatic set_capacities(int rx_value, int tx_value);
    drain_results();
    write_capacity(ubf_pkg::REG_RX_CAP, rx_value);
    write_capacity(ubf_pkg::REG_TX_CAP, tx_value);
  endtask

  function automatic ubf_pkg::in_item_t rand_fields(logic [ubf_pkg::OP_W-1:0] op);
    logic [IN_W-1:0]   raw;
    ubf_pkg::in_item_t r;
    raw  = IN_W'($urandom);
    r    = ubf_pkg::in_item_t'(raw);
    r.op = op;
    return r;
  endfunction

  task automatic rx_event(logic [ubf_pkg::BYTE_W-1:0] data, logic ne, logic ov);
    ubf_pkg::in_item_t r;
    r = rand_fields(ubf_pkg::OP_RX_EVENT);
    r.rx_data      = data;
    r.rx_not_empty = ne;
    r.rx_overrun   = ov;
    send_request(r);
  endtask

  task automatic tx_ready();
    send_request(rand_fields(ubf_pkg::OP_TX_READY));
  endtask

  task automatic host_read(int n);
    ubf_pkg::in_item_t r;
    r = rand_fields(ubf_pkg::OP_HOST_READ);
    r.burst_length = ubf_pkg::LEN_W'(n);
    send_request(r);
  endtask

  task automatic read_flags(logic [ubf_pkg::FLAG_W-1:0] mask);
    ubf_pkg::in_item_t r;
    r = rand_fields(ubf_pkg::OP_READ_FLAGS);
    r.clear_mask = mask;
    send_request(r);
  endtask

  task automatic write_byte_req(int len, logic [ubf_pkg::BYTE_W-1:0] data, logic kick);
    ubf_pkg::in_item_t r;
    r = rand_fields(ubf_pkg::OP_HOST_WRITE);
    r.burst_length = ubf_pkg::LEN_W'(len);
    r.write_byte   = data;
    r.tx_reg_empty = kick;
    send_request(r);
  endtask

  // length goes on the first byte only; later lengths are don't-care
  task automatic write_burst(int len, logic kick);
    int n;
    n = (len == 0) ? 1 : len;
    for (int i = 0; i < n; i++)
      write_byte_req((i == 0) ? len : int'($urandom_range(127)), 8'($urandom),
                     (i == n - 1) ? kick : 1'($urandom));
  endtask

  task automatic test_directed_corners();
    read_flags(2'b11);
    tx_ready();
    host_read(0);
    host_read(1);
    host_read(64);
    host_read(127);
    rx_event(8'hFF, 1'b1, 1'b1);
    rx_event(8'h00, 1'b1, 1'b0);
    rx_event(8'h5A, 1'b0, 1'b0);
    host_read(2);
    write_burst(0, 1'b1);
    write_byte_req(3, 8'hA5, 1'b0);
    rx_event(8'h3C, 1'b1, 1'b0);
    write_byte_req(99, 8'h00, 1'b0);
    write_byte_req(0, 8'hFF, 1'b1);
    write_burst(2, 1'b0);
    tx_ready();
    tx_ready();
    tx_ready();
    send_request(rand_fields(3'd5));
    send_request(rand_fields(3'd6));
    send_request(rand_fields(3'd7));
    read_flags(2'b01);
    read_flags(2'b00);
    host_read(1);
  endtask

  task automatic test_capacity_limits();
    set_capacities(1, 1);
    rx_event(8'h11, 1'b1, 1'b0);
    rx_event(8'h22, 1'b1, 1'b0);
    read_flags(2'b00);
    host_read(1);
    read_flags(2'b11);
    write_burst(2, 1'b1);
    write_burst(1, 1'b0);
    write_burst(1, 1'b1);
    tx_ready();
    write_burst(1, 1'b1);
    tx_ready();
    // saturation at both ends; a transmit size write closes an open burst
    set_capacities(0, 127);
    rx_event(8'h81, 1'b1, 1'b0);
    rx_event(8'h7E, 1'b1, 1'b1);
    write_byte_req(3, 8'hC3, 1'b0);
    drain_results();
    write_capacity(ubf_pkg::REG_TX_CAP, 5);
    write_burst(2, 1'b1);
    set_capacities(127, 0);
    write_burst(1, 1'b0);
    write_burst(1, 1'b1);
    read_flags(2'b11);
  endtask

  task automatic test_backpressure();
    set_capacities(64, 64);
    idle_pct  = 0;
    stall_pct = 0;
    @(negedge clk);
    hold_cycles = 400;
    for (int i = 0; i < 24; i++) begin
      if (i % 6 == 5) host_read(2);
      else rx_event(8'($urandom), 1'b1, 1'b0);
    end
    write_burst(4, 1'b1);
    drain_results();
    host_read(rx_fifo.size());
    tx_ready();
    drain_results();
  endtask

  task automatic random_mix(int n_items, int idle, int stall);
    int start;
    int pick;
    int sel;
    int free;
    int lvl;
    int len;
    ubf_pkg::in_item_t r;
    idle_pct  = idle;
    stall_pct = stall;
    start     = requests_sent;
    while (requests_sent - start < n_items) begin
      pick = $urandom_range(99);
      sel  = $urandom_range(9);
      if (pick < 30) begin
        rx_event(8'($urandom), ($urandom_range(9) != 0), ($urandom_range(9) == 0));
      end else if (pick < 45) begin
        tx_ready();
      end else if (pick < 70) begin
        free = tx_cap - tx_fifo.size();
        if (sel < 8) len = $urandom_range(0, (free < 6) ? free : 6);
        else if (sel == 8) len = $urandom_range(0, free);
        else len = free + $urandom_range(1, 3);
        write_burst(len, 1'($urandom));
      end else if (pick < 85) begin
        lvl = rx_fifo.size();
        if (sel < 6) len = $urandom_range(0, (lvl < 8) ? lvl : 8);
        else if (sel < 8) len = lvl;
        else if (sel == 8) len = lvl + $urandom_range(1, 2);
        else len = $urandom_range(0, 127);
        host_read(len);
      end else if (pick < 90) begin
        read_flags(2'($urandom));
      end else begin
        r = rand_fields(3'($urandom));
        if (r.op == ubf_pkg::OP_HOST_WRITE) r.burst_length = ubf_pkg::LEN_W'($urandom_range(0, 4));
        send_request(r);
      end
    end
    drain_results();
  endtask

  task automatic test_random_mix();
    set_capacities(64, 64);
    random_mix(80, 0, 0);
    set_capacities(4, 3);
    random_mix(80, 81, 0);
    set_capacities(17, 64);
    random_mix(80, 0, 81);
    set_capacities(1, 1);
    random_mix(40, 11, 11);
    set_capacities(64, 2);
    random_mix(40, 11, 11);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_capacity_limits();
    test_backpressure();
    test_random_mix();
    drain_results();
    $display("Covered %0d requests and %0d results: queue sizes 1 to 64, overflow,",
             requests_sent, results_seen);
    $display("rejected and empty bursts, long output hold-off and four pacing modes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, pending_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ubf_pkg.sv
rtl/ubf_ram.sv
rtl/ubf_ctrl.sv
rtl/ubf_dp.sv
rtl/uart_buffered_rx_tx_fifo_core.sv
tb/tb_uart_buffered_rx_tx_fifo_core.sv
